/* design/tas_pkg.sv */
// ----------------------------------------------------------------------------
// tas_pkg: shared definitions for the table additive synthesizer
// Sizes, register codes, the quarter-wave sine table, the reciprocal table
// used for the per-harmonic scaling, and the structs passed between modules.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int TABLE_DEPTH   = 512;
    localparam int MAX_HARMONICS = 16;
    localparam int SAMPLE_BITS   = 16;

    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int FRAC_W   = 16;
    localparam int OUT_W    = 19;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam int ROM_BITS = $clog2(TABLE_DEPTH);
    localparam int QIDX_W   = ROM_BITS - 1;
    localparam int QDEPTH   = TABLE_DEPTH / 4 + 1;
    localparam int HC_W     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

    localparam int RECIP_SH = SAMPLE_BITS + $clog2(MAX_HARMONICS) + 1;
    localparam int RECIP_W  = RECIP_SH + 1;

    localparam int SUM_W    = SAMPLE_BITS + HC_W + 1;
    localparam int SHL      = (SAMPLE_BITS - 1 < 15) ? 15 - (SAMPLE_BITS - 1) : 0;
    localparam int SHR      = (SAMPLE_BITS - 1 > 15) ? (SAMPLE_BITS - 1) - 15 : 0;
    localparam int EXT_W    = (SUM_W + SHL > OUT_W + 1) ? SUM_W + SHL : OUT_W + 1;
    localparam int OUT_MAX  = (1 << (OUT_W - 1)) - 1;
    localparam int OUT_MIN  = -(1 << (OUT_W - 1));

    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd4473924;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam int     RND_SH     = 30 - (SAMPLE_BITS - 1);
    localparam longint ROM_LIM    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;

    typedef enum logic [0:0] {
        REG_STEP  = 1'b0,
        REG_COUNT = 1'b1
    } reg_idx_t;

    typedef logic [SAMPLE_BITS-2:0] qrom_t [QDEPTH];
    typedef logic [RECIP_W-1:0] recip_t [MAX_HARMONICS];

    typedef struct packed {
        logic valid;
        logic act;
        logic first;
        logic last;
    } ctl_t;

    typedef struct packed {
        ctl_t                  ctl;
        logic [ROM_BITS-1:0]   idx;
        logic [FRAC_W-1:0]     frac;
        logic [HC_W-1:0]       hd;
    } issue_t;

    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] sample;
    } result_t;

    // Quotient of two nonnegative constants by shift and subtract.
    function automatic longint udiv(input longint num, input longint den);
        longint q;
        longint r;
        int     b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            if (r >= den) begin
                r = r - den;
                q = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // Taylor series of sin(x) in Q30, terms up to x^17.
    function automatic longint sine_q30(input longint x);
        longint x2;
        longint term;
        longint sum;
        int     k;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        for (k = 1; k <= 8; k++) begin
            term = udiv((term * x2) >>> 30, longint'((2 * k) * (2 * k + 1)));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        return sum;
    endfunction

    function automatic qrom_t build_qrom();
        qrom_t  rom;
        longint x;
        longint v;
        int     m;
        for (m = 0; m < QDEPTH; m++) begin
            x = (longint'(m) * TWO_PI_Q30) >>> ROM_BITS;
            v = sine_q30(x);
            v = (v + (longint'(1) <<< (RND_SH - 1))) >>> RND_SH;
            if (v > ROM_LIM) begin
                v = ROM_LIM;
            end
            rom[m] = v[SAMPLE_BITS-2:0];
        end
        return rom;
    endfunction

    // Reciprocals ceil(2^RECIP_SH / d) for divisors d = 1 .. MAX_HARMONICS.
    function automatic recip_t build_recip();
        recip_t r;
        longint d;
        int     i;
        for (i = 0; i < MAX_HARMONICS; i++) begin
            d    = longint'(i + 1);
            r[i] = RECIP_W'(udiv((longint'(1) <<< RECIP_SH) + d - 1, d));
        end
        return r;
    endfunction

    localparam qrom_t  QROM  = build_qrom();
    localparam recip_t RECIP = build_recip();

    // Full-cycle sine value rebuilt from the first quadrant.
    function automatic logic signed [SAMPLE_BITS-1:0] sine_at(
        input logic [ROM_BITS-1:0] n
    );
        logic [QIDX_W-1:0]             m;
        logic signed [SAMPLE_BITS-1:0] mag;
        m = n[QIDX_W-1:0];
        if (m > QIDX_W'(TABLE_DEPTH / 4)) begin
            m = QIDX_W'(0) - m;
        end
        mag = {1'b0, QROM[m]};
        return n[ROM_BITS-1] ? -mag : mag;
    endfunction

endpackage

/* design/tas_apb_regs.sv */
// ----------------------------------------------------------------------------
// tas_apb_regs: configuration registers
// Holds the fundamental phase step and the harmonic count behind an APB port.
// ----------------------------------------------------------------------------
module tas_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tas_pkg::ADDR_W-1:0]   paddr,
    input  logic [tas_pkg::DATA_W-1:0]   pwdata,
    output logic [tas_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [tas_pkg::STEP_W-1:0]   step,
    output logic [tas_pkg::COUNT_W-1:0]  count
);

    logic [tas_pkg::STEP_W-1:0]  step_reg;
    logic [tas_pkg::COUNT_W-1:0] count_reg;
    logic                        wr_en;
    tas_pkg::reg_idx_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign sel    = tas_pkg::reg_idx_t'(paddr[tas_pkg::ADDR_W-1]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            step_reg  <= tas_pkg::STEP_RESET;
            count_reg <= tas_pkg::COUNT_RESET;
        end else if (wr_en) begin
            unique case (sel)
                tas_pkg::REG_STEP:  step_reg  <= pwdata[tas_pkg::STEP_W-1:0];
                tas_pkg::REG_COUNT: count_reg <= pwdata[tas_pkg::COUNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            tas_pkg::REG_STEP:  prdata = step_reg;
            tas_pkg::REG_COUNT: prdata = {{(tas_pkg::DATA_W - tas_pkg::COUNT_W){1'b0}},
                                          count_reg};
        endcase
    end

    assign step  = step_reg;
    assign count = count_reg;

endmodule

/* design/tas_seq.sv */
// ----------------------------------------------------------------------------
// tas_seq: harmonic sequencer and phase store
// Steps through every harmonic once per sample, feeds its table address to the
// shared harmonic unit and advances its phase accumulator.
// ----------------------------------------------------------------------------
module tas_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tick_valid,
    output logic                         tick_stall,
    input  logic                         restart,
    input  logic [tas_pkg::STEP_W-1:0]   step,
    input  logic [tas_pkg::COUNT_W-1:0]  count,
    input  logic                         res_done,
    input  logic                         out_free,
    output tas_pkg::issue_t              issue,
    output logic                         load
);

    localparam int CMP_W = (tas_pkg::HC_W > tas_pkg::COUNT_W) ? tas_pkg::HC_W
                                                                : tas_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [tas_pkg::HC_W-1:0]     hc_reg;
    logic [tas_pkg::HC_W-1:0]     hc_next;
    logic [tas_pkg::STEP_W-1:0]   inc_reg;
    logic                         restart_reg;
    logic [tas_pkg::PHASE_W-1:0]  phase_reg [tas_pkg::MAX_HARMONICS];
    logic [tas_pkg::PHASE_W-1:0]  ph_cur;
    logic [tas_pkg::PHASE_W-1:0]  ph_new;
    logic                         accept;
    logic                         issuing;
    logic                         last;

    assign tick_stall = (state_reg != ST_IDLE);
    assign accept     = tick_valid & ~tick_stall;
    assign issuing    = (state_reg == ST_ISSUE);
    assign last       = (hc_reg == tas_pkg::HC_W'(tas_pkg::MAX_HARMONICS - 1));
    assign load       = (state_reg == ST_DONE) & out_free;

    // A restart zeroes every phase on its way through, before it is used.
    assign ph_cur = restart_reg ? '0 : phase_reg[hc_reg];
    assign ph_new = ph_cur + inc_reg;

    always_comb begin
        issue.ctl.valid = issuing;
        issue.ctl.act   = (CMP_W'(hc_reg) < CMP_W'(count));
        issue.ctl.first = (hc_reg == '0);
        issue.ctl.last  = last;
        issue.idx       = ph_cur[tas_pkg::PHASE_W-1 -: tas_pkg::ROM_BITS];
        issue.frac      = ph_cur[tas_pkg::PHASE_W-1-tas_pkg::ROM_BITS -: tas_pkg::FRAC_W];
        issue.hd        = hc_reg;
    end

    always_comb begin
        state_next = state_reg;
        hc_next    = hc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (last) begin
                    state_next = ST_WAIT;
                    hc_next    = '0;
                end else begin
                    hc_next = hc_reg + tas_pkg::HC_W'(1);
                end
            end
            ST_WAIT: begin
                if (res_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                hc_next    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            hc_reg    <= '0;
            for (int i = 0; i < tas_pkg::MAX_HARMONICS; i++) begin
                phase_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            hc_reg    <= hc_next;
            if (issuing) begin
                phase_reg[hc_reg] <= ph_new;
            end
        end
    end

    // The increment register walks through p times the step, one add per harmonic.
    always_ff @(posedge clk) begin
        if (accept) begin
            inc_reg     <= step;
            restart_reg <= restart;
        end else if (issuing) begin
            inc_reg <= inc_reg + step;
        end
    end

    a_idle_hc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> hc_reg == '0)
        else $error("harmonic counter not at zero while idle");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ISSUE && hc_reg == '0))
        else $error("accepted beat did not start the harmonic sweep");

    a_last_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (issuing && last) |=> state_reg == ST_WAIT)
        else $error("sweep did not end after the last harmonic");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        res_done |-> state_reg == ST_WAIT)
        else $error("harmonic unit finished a sample outside the wait state");

endmodule

/* design/tas_harm_unit.sv */
// ----------------------------------------------------------------------------
// tas_harm_unit: shared harmonic pipeline
// Reads and interpolates the sine table for one harmonic per cycle, divides
// by the harmonic number, accumulates, and converts the finished sum.
// ----------------------------------------------------------------------------
module tas_harm_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  tas_pkg::issue_t   issue,
    output tas_pkg::result_t  result
);

    localparam int SB  = tas_pkg::SAMPLE_BITS;
    localparam int PQ_W = SB + tas_pkg::RECIP_W;
    localparam logic signed [tas_pkg::EXT_W-1:0] SAT_HI = tas_pkg::EXT_W'(tas_pkg::OUT_MAX);
    localparam logic signed [tas_pkg::EXT_W-1:0] SAT_LO = tas_pkg::EXT_W'(tas_pkg::OUT_MIN);

    tas_pkg::ctl_t s1_ctl_reg;
    tas_pkg::ctl_t s2_ctl_reg;
    tas_pkg::ctl_t s3_ctl_reg;
    tas_pkg::ctl_t s4_ctl_reg;
    tas_pkg::ctl_t s5_ctl_reg;

    logic [tas_pkg::ROM_BITS-1:0] s1_idx_reg;
    logic [tas_pkg::FRAC_W-1:0]   s1_frac_reg;
    logic [tas_pkg::HC_W-1:0]     s1_hd_reg;

    logic signed [SB-1:0]         s2_ti_reg;
    logic signed [SB-1:0]         s2_tj_reg;
    logic [tas_pkg::FRAC_W-1:0]   s2_frac_reg;
    logic [tas_pkg::HC_W-1:0]     s2_hd_reg;

    logic signed [SB-1:0]         s3_ti_reg;
    logic signed [SB+17:0]        s3_prod_reg;
    logic [tas_pkg::HC_W-1:0]     s3_hd_reg;

    logic [SB-1:0]                s4_a_reg;
    logic                         s4_neg_reg;
    logic [tas_pkg::HC_W-1:0]     s4_hd_reg;

    logic [PQ_W-1:0]              s5_prodq_reg;
    logic                         s5_neg_reg;

    logic signed [tas_pkg::SUM_W-1:0] acc_reg;
    logic signed [tas_pkg::SUM_W-1:0] acc_next;
    logic                             done_reg;
    logic signed [tas_pkg::OUT_W-1:0] sample_reg;
    logic signed [tas_pkg::OUT_W-1:0] sample_next;

    logic [tas_pkg::ROM_BITS-1:0] idx_nx;
    logic signed [SB-1:0]         ti;
    logic signed [SB-1:0]         tj;
    logic signed [SB:0]           diff;
    logic signed [SB+17:0]        prod;
    logic signed [SB+17:0]        prod_sh;
    logic [SB+1:0]                v_u;
    logic [SB+1:0]                a_wide;
    logic                         v_neg;
    logic [PQ_W-1:0]              prodq;
    logic [SB-1:0]                q;
    logic signed [SB:0]           q_s;
    logic signed [tas_pkg::SUM_W-1:0] term;
    logic signed [tas_pkg::SUM_W-1:0] acc_base;
    logic signed [tas_pkg::EXT_W-1:0] ext;
    logic signed [tas_pkg::EXT_W-1:0] conv;

    // Table reads of the entry and its neighbor, which wraps past the end.
    assign idx_nx = s1_idx_reg + tas_pkg::ROM_BITS'(1);
    assign ti     = tas_pkg::sine_at(s1_idx_reg);
    assign tj     = tas_pkg::sine_at(idx_nx);

    // Interpolation as ti + floor((tj - ti) * f / 2^16).
    assign diff   = {s2_tj_reg[SB-1], s2_tj_reg} - {s2_ti_reg[SB-1], s2_ti_reg};
    assign prod   = diff * $signed({1'b0, s2_frac_reg});

    // Floor division by d = hd + 1 works on a magnitude: a negative value
    // becomes (-v + d - 1), and the quotient is negated afterwards.
    assign prod_sh = s3_prod_reg >>> tas_pkg::FRAC_W;
    assign v_u     = {s3_ti_reg[SB-1], s3_ti_reg[SB-1], s3_ti_reg} + prod_sh[SB+1:0];
    assign v_neg   = v_u[SB+1];
    assign a_wide  = v_neg ? ((SB + 2)'(s3_hd_reg) - v_u) : v_u;

    assign prodq = PQ_W'(s4_a_reg) * PQ_W'(tas_pkg::RECIP[s4_hd_reg]);

    assign q        = s5_prodq_reg[tas_pkg::RECIP_SH +: SB];
    assign q_s      = s5_neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    assign term     = s5_ctl_reg.act ? tas_pkg::SUM_W'(q_s) : '0;
    assign acc_base = s5_ctl_reg.first ? '0 : acc_reg;
    assign acc_next = acc_base + term;

    assign ext  = tas_pkg::EXT_W'(acc_next);
    assign conv = (ext <<< tas_pkg::SHL) >>> tas_pkg::SHR;

    always_comb begin
        priority if (conv > SAT_HI) begin
            sample_next = SAT_HI[tas_pkg::OUT_W-1:0];
        end else if (conv < SAT_LO) begin
            sample_next = SAT_LO[tas_pkg::OUT_W-1:0];
        end else begin
            sample_next = conv[tas_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            s1_ctl_reg <= issue.ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            done_reg   <= s5_ctl_reg.valid & s5_ctl_reg.last;
        end
    end

    always_ff @(posedge clk) begin
        s1_idx_reg   <= issue.idx;
        s1_frac_reg  <= issue.frac;
        s1_hd_reg    <= issue.hd;
        s2_ti_reg    <= ti;
        s2_tj_reg    <= tj;
        s2_frac_reg  <= s1_frac_reg;
        s2_hd_reg    <= s1_hd_reg;
        s3_ti_reg    <= s2_ti_reg;
        s3_prod_reg  <= prod;
        s3_hd_reg    <= s2_hd_reg;
        s4_a_reg     <= a_wide[SB-1:0];
        s4_neg_reg   <= v_neg;
        s4_hd_reg    <= s3_hd_reg;
        s5_prodq_reg <= prodq;
        s5_neg_reg   <= s4_neg_reg;
        if (s5_ctl_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (s5_ctl_reg.valid && s5_ctl_reg.last) begin
            sample_reg <= sample_next;
        end
    end

    assign result.done   = done_reg;
    assign result.sample = sample_reg;

endmodule

/* design/table_additive_synth.sv */
// ----------------------------------------------------------------------------
// table_additive_synth: additive synthesizer over a sine wavetable
// Each tick beat makes one sample beat: the sum over the enabled harmonics of
// an interpolated sine value at each harmonic's phase, divided by its number.
//
// Channels: the tick channel carries the restart flag; the sample channel
// carries a signed Q3.15 sample, saturated. Both use valid and stall.
// The APB port holds the fundamental step (address 0) and the harmonic count
// (address 4); write them only while no tick is in flight.
// Timing: the sequencer issues all sixteen harmonics, one per cycle, whatever
// the harmonic count; the last one leaves the five-stage harmonic pipeline,
// raises the done flag, moves the sequencer to its done state and is loaded
// into the output register once that is free. The block takes no new tick
// until the previous sum has been loaded into the output register.
// A finished sample sits in the output register while the next tick is
// worked on; if it is still stalled when the next sum is ready, the block
// holds that sum and keeps the tick channel stalled until the register frees.
// Reset clears all phases to zero, restores the register defaults and drops
// the sample valid.
// ----------------------------------------------------------------------------
module table_additive_synth (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tas_pkg::ADDR_W-1:0]         paddr,
    input  logic [tas_pkg::DATA_W-1:0]         pwdata,
    output logic [tas_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               tick_valid,
    output logic                               tick_stall,
    input  logic                               restart,
    output logic                               sample_valid,
    input  logic                               sample_stall,
    output logic signed [tas_pkg::OUT_W-1:0]   sample
);

    logic [tas_pkg::STEP_W-1:0]        step;
    logic [tas_pkg::COUNT_W-1:0]       count;
    tas_pkg::issue_t                   issue;
    tas_pkg::result_t                  result;
    logic                              load;
    logic                              out_free;
    logic                              sample_valid_reg;
    logic signed [tas_pkg::OUT_W-1:0]  sample_reg;

    assign out_free = ~sample_valid_reg | ~sample_stall;

    tas_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .step    (step),
        .count   (count)
    );

    tas_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .restart    (restart),
        .step       (step),
        .count      (count),
        .res_done   (result.done),
        .out_free   (out_free),
        .issue      (issue),
        .load       (load)
    );

    tas_harm_unit u_harm (
        .clk    (clk),
        .rst_n  (rst_n),
        .issue  (issue),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sample_valid_reg <= 1'b0;
        end else if (load) begin
            sample_valid_reg <= 1'b1;
        end else if (!sample_stall) begin
            sample_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            sample_reg <= result.sample;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign sample       = sample_reg;

endmodule

/* dv/table_additive_synth_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_additive_synth_checker: sample predictor and scoreboard
// Watches the APB port, the tick channel and the sample channel. It keeps its
// own copy of the fundamental step, the harmonic count and the sixteen phase
// accumulators, predicts one sample for every tick beat taken, and compares
// every sample beat against the oldest prediction. Register reads are checked
// against the shadow copy. The mismatch count and the number of samples
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module table_additive_synth_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tas_pkg::ADDR_W-1:0]         paddr,
    input  logic [tas_pkg::DATA_W-1:0]         pwdata,
    input  logic [tas_pkg::DATA_W-1:0]         prdata,
    input  logic                               pready,
    input  logic                               tick_valid,
    input  logic                               tick_stall,
    input  logic                               restart,
    input  logic                               sample_valid,
    input  logic                               sample_stall,
    input  logic signed [tas_pkg::OUT_W-1:0]   sample,
    output int                                 mismatches,
    output int                                 pending
);

    localparam int     TAB_N     = 512;
    localparam int     TAB_BITS  = 9;
    localparam int     HARM_N    = 16;
    localparam int     TAB_FRAC  = 15;
    localparam longint TURN_Q30  = 64'sd6746518852;
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint SAT_HI    = 262143;
    localparam longint SAT_LO    = -262144;

    logic signed [15:0]                sine_tab [TAB_N];
    logic [31:0]                       phase_acc [HARM_N];
    logic [31:0]                       step_reg = 32'd4473924;
    logic [4:0]                        count_reg = 5'd10;
    logic signed [tas_pkg::OUT_W-1:0]  expected_samples [$];
    int                                err_cnt = 0;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic longint taylor_sin_q30(input longint x);
        longint sq;
        longint term;
        longint acc;
        int     k;
        sq   = (x * x) >>> 30;
        term = x;
        acc  = x;
        for (k = 1; k <= 8; k++) begin
            term = ((term * sq) >>> 30) / longint'(2 * k * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        return acc;
    endfunction

    initial begin
        longint v;
        int     n;
        int     m;
        for (n = 0; n < TAB_N; n++) begin
            m = n % (TAB_N / 2);
            if (m > TAB_N / 4) begin
                m = TAB_N / 2 - m;
            end
            v = taylor_sin_q30((longint'(m) * TURN_Q30) / TAB_N);
            v = (v + (longint'(1) <<< (30 - TAB_FRAC - 1))) >>> (30 - TAB_FRAC);
            if (v > (longint'(1) <<< TAB_FRAC) - 1) begin
                v = (longint'(1) <<< TAB_FRAC) - 1;
            end
            sine_tab[n] = (n >= TAB_N / 2) ? 16'(-v) : 16'(v);
        end
    end

    // Produces the sample for one tick and moves every phase on by its harmonic number times the step.
    function automatic logic signed [tas_pkg::OUT_W-1:0] synth_sample(input logic rs);
        longint             total;
        longint             interp;
        longint             scaled;
        logic [TAB_BITS-1:0] idx;
        logic [15:0]        frac;
        int                 used;
        int                 p;
        if (rs) begin
            for (p = 0; p < HARM_N; p++) begin
                phase_acc[p] = '0;
            end
        end
        used  = (count_reg > HARM_N) ? HARM_N : int'(count_reg);
        total = 0;
        for (p = 0; p < used; p++) begin
            idx    = phase_acc[p][31 -: TAB_BITS];
            frac   = phase_acc[p][31-TAB_BITS -: 16];
            interp = longint'(sine_tab[idx]) * (65536 - longint'(frac))
                   + longint'(sine_tab[TAB_BITS'(idx + 1'b1)]) * longint'(frac);
            interp = interp >>> 16;
            scaled = interp / longint'(p + 1);
            if ((interp % longint'(p + 1)) != 0 && interp < 0) begin
                scaled = scaled - 1;
            end
            total = total + scaled;
        end
        for (p = 0; p < HARM_N; p++) begin
            phase_acc[p] = phase_acc[p] + 32'(longint'(p + 1) * longint'(step_reg));
        end
        if (total > SAT_HI) begin
            total = SAT_HI;
        end
        if (total < SAT_LO) begin
            total = SAT_LO;
        end
        return tas_pkg::OUT_W'(total);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic signed [tas_pkg::OUT_W-1:0] want;
        logic [tas_pkg::DATA_W-1:0]       reg_val;
        int                               p;
        if (!rst_n) begin
            for (p = 0; p < HARM_N; p++) begin
                phase_acc[p] = '0;
            end
            step_reg  = 32'd4473924;
            count_reg = 5'd10;
            expected_samples.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pready) begin
                reg_val = (tas_pkg::reg_idx_t'(paddr[tas_pkg::ADDR_W-1:2]) == tas_pkg::REG_STEP)
                        ? step_reg : tas_pkg::DATA_W'(count_reg);
                if (pwrite) begin
                    case (tas_pkg::reg_idx_t'(paddr[tas_pkg::ADDR_W-1:2]))
                        tas_pkg::REG_STEP:  step_reg  = pwdata;
                        tas_pkg::REG_COUNT: count_reg = pwdata[4:0];
                        default:            ;
                    endcase
                end else if (prdata !== reg_val) begin
                    err_cnt++;
                    $display("%0t: register read at %0d, expected %0d, got %0d",
                             $time, paddr, reg_val, prdata);
                end
            end
            if (tick_valid && !tick_stall) begin
                expected_samples.push_back(synth_sample(restart));
            end
            if (sample_valid && !sample_stall) begin
                if (expected_samples.size() == 0) begin
                    err_cnt++;
                    $display("%0t: sample beat with none expected, expected none, got %0d",
                             $time, sample);
                end else begin
                    want = expected_samples.pop_front();
                    if (sample !== want) begin
                        err_cnt++;
                        $display("%0t: sample mismatch, expected %0d, got %0d",
                                 $time, want, sample);
                    end
                end
            end
            pending    <= expected_samples.size();
            mismatches <= err_cnt;
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the table additive synthesizer
// Resets the block, then plays a short directed set of tones (register
// extremes, restart, zero and oversized harmonic counts, phase wrap past the
// last table entry) followed by random tones in bursts of tick beats. The
// sample side stalls on its own random pattern and once holds off long enough
// for the block to back up. A separate checker predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES  = 40;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [tas_pkg::ADDR_W-1:0]        paddr = '0;
    logic [tas_pkg::DATA_W-1:0]        pwdata = '0;
    logic [tas_pkg::DATA_W-1:0]        prdata;
    logic                              pready;
    logic                              tick_valid = 1'b0;
    logic                              tick_stall;
    logic                              restart = 1'b0;
    logic                              sample_valid;
    logic                              sample_stall = 1'b0;
    logic signed [tas_pkg::OUT_W-1:0]  sample;
    int                                mismatches;
    int                                pending;
    int                                hold_len = 0;
    int                                idle_cycles = 0;

    table_additive_synth u_dut (.*);

    table_additive_synth_checker u_checker (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    task automatic apb_access(input tas_pkg::reg_idx_t idx, input logic wr,
                              input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= tas_pkg::ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_tone(input logic [31:0] step, input logic [31:0] count);
        apb_access(tas_pkg::REG_STEP, 1'b1, step);
        apb_access(tas_pkg::REG_COUNT, 1'b1, count);
        apb_access(tas_pkg::REG_STEP, 1'b0, '0);
        apb_access(tas_pkg::REG_COUNT, 1'b0, '0);
    endtask

    task automatic send_tick(input logic rs);
        tick_valid <= 1'b1;
        restart    <= rs;
        do @(posedge clk); while (tick_stall);
    endtask

    task automatic run_ticks(input int n, input int restart_odds, input int max_gap,
                             input logic lead_restart);
        int   burst;
        int   k;
        logic rs;
        burst = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            rs = (k == 0 && lead_restart) ||
                 (restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
            send_tick(rs);
            burst--;
            if (burst == 0 && k != n - 1) begin
                burst = $urandom_range(1, 12);
                if (max_gap > 0 && $urandom_range(0, 3) != 0) begin
                    tick_valid <= 1'b0;
                    restart    <= 1'($urandom_range(0, 1));
                    repeat ($urandom_range(1, max_gap)) @(posedge clk);
                end
            end
        end
        tick_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        do @(posedge clk); while (pending != 0);
    endtask

    // Sample-side stall pattern, with one long hold-off when asked for.
    initial begin
        int mode;
        int seg;
        int k;
        forever begin
            if (hold_len > 0) begin
                sample_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(10, 80);
            for (k = 0; k < seg; k++) begin
                case (mode)
                    0:       sample_stall <= 1'b0;
                    1:       sample_stall <= ($urandom_range(0, 3) == 0);
                    2:       sample_stall <= ($urandom_range(0, 3) != 0);
                    default: sample_stall <= ((k % 8) < 5);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (tick_valid && !tick_stall) || (sample_valid && !sample_stall) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL table_additive_synth");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] step;
        logic [31:0] count;
        int          ph;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed tones.
        apb_access(tas_pkg::REG_STEP, 1'b0, '0);
        apb_access(tas_pkg::REG_COUNT, 1'b0, '0);
        run_ticks(4, 0, 0, 1'b1);
        drain();
        set_tone(32'h8000_0000, 32'd16);
        run_ticks(3, 0, 0, 1'b1);
        drain();
        set_tone(32'hFFFF_FFFF, 32'd1);
        run_ticks(3, 0, 0, 1'b1);
        drain();
        set_tone(32'h0123_4567, 32'd0);
        run_ticks(2, 0, 0, 1'b0);
        drain();
        set_tone(32'h0123_4567, 32'd31);
        run_ticks(3, 0, 0, 1'b0);
        drain();
        set_tone(32'h0000_0000, 32'hFFFF_FFF1);
        run_ticks(2, 0, 0, 1'b1);
        drain();
        set_tone(32'h7FFF_FFFF, 32'd16);
        run_ticks(3, 0, 0, 1'b0);

        // Random tones.
        for (ph = 0; ph < 10; ph++) begin
            drain();
            case ($urandom_range(0, 3))
                0:       step = $urandom;
                1:       step = $urandom_range(0, 32'h0100_0000);
                2:       step = 32'hFFFF_FFFF - $urandom_range(0, 32'h0100_0000);
                default: step = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h0000_0001;
            endcase
            count = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 31))
                                               : 32'($urandom_range(1, 16));
            set_tone(step, count);
            if (ph == 4) begin
                hold_len = HOLD_CYCLES;
                run_ticks(96, 16, 0, 1'b0);
            end else begin
                run_ticks(96, 16, (ph % 3 == 0) ? 0 : 60, 1'b0);
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("PASS table_additive_synth");
        end else begin
            $display("FAIL table_additive_synth");
        end
        $finish;
    end

endmodule
